>>> hw/rtl/cidc_pkg.sv
package cidc_pkg;

   // Opcodes of an input item
   localparam logic [3:0] OP_TICK      = 4'd0;
   localparam logic [3:0] OP_MODE      = 4'd1;
   localparam logic [3:0] OP_PRESENCE  = 4'd2;
   localparam logic [3:0] OP_RAIN      = 4'd3;
   localparam logic [3:0] OP_LAMP      = 4'd4;
   localparam logic [3:0] OP_PUMP      = 4'd5;
   localparam logic [3:0] OP_FAN       = 4'd6;
   localparam logic [3:0] OP_FAN_SPEED = 4'd7;
   localparam logic [3:0] OP_ZERO_X    = 4'd8;
   localparam logic [3:0] OP_DIM_TICK  = 4'd9;

   // Operating modes
   localparam logic [1:0] MD_MANUAL = 2'd0;
   localparam logic [1:0] MD_AUTO   = 2'd1;
   localparam logic [1:0] MD_SMART  = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_TEMP_SETPOINT = 3'd0;
   localparam logic [2:0] REG_TEMP_BAND     = 3'd1;
   localparam logic [2:0] REG_SOIL_SETPOINT = 3'd2;
   localparam logic [2:0] REG_SOIL_BAND     = 3'd3;
   localparam logic [2:0] REG_FAN_DEFAULT   = 3'd4;
   localparam logic [2:0] REG_FIRE_ANGLE    = 3'd5;

   // Register reset values
   localparam logic signed [11:0] TEMP_SETPOINT_RST = 12'sd300;
   localparam logic [8:0]         TEMP_BAND_RST     = 9'd20;
   localparam logic [6:0]         SOIL_SETPOINT_RST = 7'd40;
   localparam logic [6:0]         SOIL_BAND_RST     = 7'd10;
   localparam logic [7:0]         FAN_DEFAULT_RST   = 8'd200;
   localparam logic [7:0]         FIRE_ANGLE_RST    = 8'd90;

   localparam logic [7:0]  SPEED_MAX  = 8'hFF;
   localparam logic [15:0] ARG_ON     = 16'd1;
   localparam logic [7:0]  FLAG_TRUE  = 8'd1;
   localparam logic [7:0]  FLAG_FALSE = 8'd0;

   typedef struct packed {
      logic [3:0]         opcode;
      logic [15:0]        argument;
      logic signed [11:0] temperature;
      logic [6:0]         soil_percent;
   } req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       lamp_on;
      logic       triac_gate;
      logic       pump_on;
      logic       fan_on;
      logic [7:0] fan_duty;
      logic       fan_blocked;
      logic       pump_blocked;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [11:0] data;
   } csr_type;

   // Write strobe handed to the state unit
   typedef struct packed {
      logic        en;
      logic [2:0]  index;
      logic [11:0] data;
   } csr_wr_type;

endpackage

>>> hw/rtl/cidc_chan_if.sv
interface cidc_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/climate_irrigation_dimmer_controller.sv
// Climate, irrigation and lamp-dimmer controller. Each opcode-tagged transfer on req_if
// (control tick, mode, presence, rain, lamp, pump, fan switch, fan speed, zero cross,
// dimmer tick) updates the controller state and yields exactly one transfer on rsp_if
// showing the mode, outputs and blocked flags after that item. Items with unknown opcodes
// produce a result with the state unchanged. Throughput is one item per clock while rsp_if
// is ready. An item passes through one input register, then the state update logic writes
// state and the result register in the same edge. The next item sees the state left by
// the previous one because the state registers update as the result is captured. A full
// result register stalls the input register, which in turn drops req_if.ready; ready is
// combinational from rsp_if.ready. Registers on csr_if (index 0 temp setpoint, 1 temp
// band, 2 soil setpoint, 3 soil band, 4 fan default duty, 5 fire angle) are always
// ready and must be written while no item is in flight; indexes above 5 are ignored.
module climate_irrigation_dimmer_controller (
   input logic         clock,
   input logic         reset,
   cidc_chan_if.sink   req_if,
   cidc_chan_if.source rsp_if,
   cidc_chan_if.sink   csr_if
);
   import cidc_pkg::*;

   // input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_item_ff;
   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic       s1_adv;
   csr_wr_type csr_wr;
   rsp_type    rsp_next;
   csr_type    csr_data;

   // stage 1 moves on when the result slot is free or being drained
   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign s1_valid_in  = req_if.valid || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_if.ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         s1_item_ff <= req_if.data;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_next;
      end
   end

   assign csr_if.ready = 1'b1;
   assign csr_data     = csr_if.data;
   assign csr_wr.en    = csr_if.valid;
   assign csr_wr.index = csr_data.index;
   assign csr_wr.data  = csr_data.data;

   cidc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .csr_wr   (csr_wr),
      .item_en  (s1_adv),
      .item     (s1_item_ff),
      .rsp_next (rsp_next)
   );

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_ff;

   // input stage must hold when the result slot is stuck
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("input taken while pipeline stalled");
   // every item leaving stage 1 lands in the result register
   a_land: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("item lost between stages");
   // reset empties both stages
   a_reset: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");
   // result shows no duty while fan is off
   a_rsp_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.fan_on || rsp_ff.fan_duty == 8'd0))
      else $error("result duty without fan on");

endmodule

>>> hw/rtl/cidc_core.sv
module cidc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  cidc_pkg::csr_wr_type csr_wr,
   input  logic                 item_en,
   input  cidc_pkg::req_type    item,
   output cidc_pkg::rsp_type    rsp_next
);
   import cidc_pkg::*;

   // Configuration registers
   logic signed [11:0] temp_sp_ff;
   logic [8:0]         temp_band_ff;
   logic [6:0]         soil_sp_ff;
   logic [6:0]         soil_band_ff;
   logic [7:0]         fan_dflt_ff;
   logic [7:0]         fire_angle_ff;

   // Controller state
   logic [1:0] mode_ff,       mode_in;
   logic       lamp_ff,       lamp_in;
   logic       armed_ff,      armed_in;
   logic [7:0] phase_ff,      phase_in;
   logic       gate_ff,       gate_in;
   logic       pump_ff,       pump_in;
   logic       fan_ff,        fan_in;
   logic [7:0] speed_ff,      speed_in;
   logic [7:0] last_speed_ff, last_speed_in;
   logic [7:0] presence_ff,   presence_in;
   logic [7:0] rain_ff,       rain_in;
   logic       fan_blk_ff,    fan_blk_in;
   logic       pump_blk_ff,   pump_blk_in;

   logic signed [12:0] temp_x;
   logic signed [12:0] temp_sp_x;
   logic signed [12:0] temp_off;
   logic [7:0]         soil_off;
   logic               is_on;
   logic               manual;
   logic               smart;
   logic [7:0]         sat_speed;
   logic [7:0]         phase_inc;
   logic [7:0]         fan_on_speed;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_sp_ff    <= TEMP_SETPOINT_RST;
         temp_band_ff  <= TEMP_BAND_RST;
         soil_sp_ff    <= SOIL_SETPOINT_RST;
         soil_band_ff  <= SOIL_BAND_RST;
         fan_dflt_ff   <= FAN_DEFAULT_RST;
         fire_angle_ff <= FIRE_ANGLE_RST;
      end else if (csr_wr.en) begin
         case (csr_wr.index)
            REG_TEMP_SETPOINT: temp_sp_ff    <= csr_wr.data;
            REG_TEMP_BAND:     temp_band_ff  <= csr_wr.data[8:0];
            REG_SOIL_SETPOINT: soil_sp_ff    <= csr_wr.data[6:0];
            REG_SOIL_BAND:     soil_band_ff  <= csr_wr.data[6:0];
            REG_FAN_DEFAULT:   fan_dflt_ff   <= csr_wr.data[7:0];
            REG_FIRE_ANGLE:    fire_angle_ff <= csr_wr.data[7:0];
            default: begin
            end
         endcase
      end
   end

   assign temp_x    = {item.temperature[11], item.temperature};
   assign temp_sp_x = {temp_sp_ff[11], temp_sp_ff};
   assign temp_off  = temp_sp_x - $signed({4'b0000, temp_band_ff});
   assign soil_off  = {1'b0, soil_sp_ff} + {1'b0, soil_band_ff};
   assign is_on     = (item.argument == ARG_ON);
   assign manual    = (mode_ff == MD_MANUAL);
   assign smart     = (mode_ff == MD_SMART);
   assign sat_speed = (|item.argument[15:8]) ? SPEED_MAX : item.argument[7:0];
   assign phase_inc = (phase_ff == SPEED_MAX) ? phase_ff : phase_ff + 8'd1;
   // first manual on after a zero speed falls back to the default duty
   assign fan_on_speed = (last_speed_ff == 8'd0) ? fan_dflt_ff : last_speed_ff;

   always_comb begin
      mode_in       = mode_ff;
      lamp_in       = lamp_ff;
      armed_in      = armed_ff;
      phase_in      = phase_ff;
      gate_in       = gate_ff;
      pump_in       = pump_ff;
      fan_in        = fan_ff;
      speed_in      = speed_ff;
      last_speed_in = last_speed_ff;
      presence_in   = presence_ff;
      rain_in       = rain_ff;
      fan_blk_in    = fan_blk_ff;
      pump_blk_in   = pump_blk_ff;
      case (item.opcode)
         OP_TICK: begin
            if (mode_ff == MD_AUTO || smart) begin
               if (temp_x >= temp_sp_x) begin
                  fan_in   = !smart || (presence_ff == FLAG_TRUE);
                  speed_in = fan_in ? fan_dflt_ff : 8'd0;
               end else if (temp_x <= temp_off) begin
                  fan_in   = 1'b0;
                  speed_in = 8'd0;
               end
               if (item.soil_percent <= soil_sp_ff) begin
                  pump_in = !smart || (rain_ff == FLAG_FALSE);
               end else if ({1'b0, item.soil_percent} >= soil_off) begin
                  pump_in = 1'b0;
               end
            end
         end
         OP_MODE: begin
            if (item.argument <= {14'd0, MD_SMART}) begin
               mode_in = item.argument[1:0];
            end
            fan_blk_in  = 1'b0;
            pump_blk_in = 1'b0;
         end
         OP_PRESENCE: presence_in = item.argument[7:0];
         OP_RAIN:     rain_in     = item.argument[7:0];
         OP_LAMP: begin
            lamp_in  = is_on;
            armed_in = is_on;
         end
         OP_PUMP: begin
            if (!manual) begin
               pump_blk_in = 1'b1;
            end else begin
               pump_in = is_on;
            end
         end
         OP_FAN: begin
            if (!manual) begin
               fan_blk_in = 1'b1;
            end else if (is_on) begin
               last_speed_in = fan_on_speed;
               fan_in        = 1'b1;
               speed_in      = fan_on_speed;
            end else begin
               fan_in   = 1'b0;
               speed_in = 8'd0;
            end
         end
         OP_FAN_SPEED: begin
            if (manual) begin
               fan_in        = (sat_speed != 8'd0);
               speed_in      = sat_speed;
               last_speed_in = sat_speed;
            end
         end
         OP_ZERO_X: begin
            phase_in = 8'd0;
            gate_in  = 1'b0;
         end
         OP_DIM_TICK: begin
            phase_in = phase_inc;
            if (lamp_ff && armed_ff && phase_inc == fire_angle_ff) begin
               gate_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MD_MANUAL;
         lamp_ff       <= 1'b0;
         armed_ff      <= 1'b0;
         phase_ff      <= 8'd0;
         gate_ff       <= 1'b0;
         pump_ff       <= 1'b0;
         fan_ff        <= 1'b0;
         speed_ff      <= 8'd0;
         last_speed_ff <= FAN_DEFAULT_RST;
         presence_ff   <= FLAG_TRUE;
         rain_ff       <= FLAG_FALSE;
         fan_blk_ff    <= 1'b0;
         pump_blk_ff   <= 1'b0;
      end else if (item_en) begin
         mode_ff       <= mode_in;
         lamp_ff       <= lamp_in;
         armed_ff      <= armed_in;
         phase_ff      <= phase_in;
         gate_ff       <= gate_in;
         pump_ff       <= pump_in;
         fan_ff        <= fan_in;
         speed_ff      <= speed_in;
         last_speed_ff <= last_speed_in;
         presence_ff   <= presence_in;
         rain_ff       <= rain_in;
         fan_blk_ff    <= fan_blk_in;
         pump_blk_ff   <= pump_blk_in;
      end
   end

   assign rsp_next.mode         = mode_in;
   assign rsp_next.lamp_on      = lamp_in;
   assign rsp_next.triac_gate   = gate_in;
   assign rsp_next.pump_on      = pump_in;
   assign rsp_next.fan_on       = fan_in;
   assign rsp_next.fan_duty     = speed_in;
   assign rsp_next.fan_blocked  = fan_blk_in;
   assign rsp_next.pump_blocked = pump_blk_in;

   // fan duty only nonzero while fan is enabled
   a_duty_off: assert property (@(posedge clock) disable iff (reset)
      !fan_ff |-> speed_ff == 8'd0)
      else $error("fan duty set while fan off");
   // phase counter never wraps
   a_phase_sat: assert property (@(posedge clock) disable iff (reset)
      (item_en && item.opcode == OP_DIM_TICK) |=> phase_ff >= $past(phase_ff))
      else $error("phase counter wrapped");
   // lamp off never raises the gate
   a_gate_lamp: assert property (@(posedge clock) disable iff (reset)
      (item_en && !lamp_ff && !gate_ff) |=> !gate_ff)
      else $error("triac fired with lamp off");

endmodule

>>> test/climate_irrigation_dimmer_controller_test.sv
module climate_irrigation_dimmer_controller_test;
   import cidc_pkg::*;

   // Opcodes the block does not decode; they must echo the state unchanged
   localparam logic [3:0] OP_SPARE_LO = 4'd10;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;
   // First register index past the decoded set; writes there are dropped
   localparam logic [2:0] REG_SPARE   = 3'd6;

   // Mirror of the controller: register copy, state copy, and the statuses
   // still owed by the block, oldest first.
   class controller_shadow;
      logic signed [11:0] temp_sp;
      logic [8:0]         temp_hyst;
      logic [6:0]         soil_sp, soil_hyst;
      logic [7:0]         fan_dflt, fire_at;

      logic [1:0] mode;
      logic       lamp, armed, gate, pump, fan, fan_blk, pump_blk;
      logic [7:0] phase, duty, last_duty, presence, raining;

      rsp_type due_status[$];
      int      errors;

      function void clear();
         temp_sp   = TEMP_SETPOINT_RST;
         temp_hyst = TEMP_BAND_RST;
         soil_sp   = SOIL_SETPOINT_RST;
         soil_hyst = SOIL_BAND_RST;
         fan_dflt  = FAN_DEFAULT_RST;
         fire_at   = FIRE_ANGLE_RST;
         mode      = MD_MANUAL;
         lamp      = 1'b0;
         armed     = 1'b0;
         gate      = 1'b0;
         pump      = 1'b0;
         fan       = 1'b0;
         fan_blk   = 1'b0;
         pump_blk  = 1'b0;
         phase     = 8'd0;
         duty      = 8'd0;
         last_duty = FAN_DEFAULT_RST;
         presence  = FLAG_TRUE;
         raining   = FLAG_FALSE;
         errors    = 0;
         due_status.delete();
      endfunction

      function void write_reg(logic [2:0] idx, logic [11:0] val);
         case (idx)
            REG_TEMP_SETPOINT: temp_sp   = val;
            REG_TEMP_BAND:     temp_hyst = val[8:0];
            REG_SOIL_SETPOINT: soil_sp   = val[6:0];
            REG_SOIL_BAND:     soil_hyst = val[6:0];
            REG_FAN_DEFAULT:   fan_dflt  = val[7:0];
            REG_FIRE_ANGLE:    fire_at   = val[7:0];
            default: ;
         endcase
      endfunction

      function void fan_drive(logic on, logic [7:0] d);
         fan  = on;
         duty = on ? d : 8'd0;
      endfunction

      // Hysteresis rules; compared in int so nothing wraps
      function void climate_tick(int t, int s);
         int   tsp, ssp;
         logic smart;
         tsp   = temp_sp;
         ssp   = soil_sp;
         smart = (mode == MD_SMART);
         if (mode != MD_AUTO && !smart) return;
         if (t >= tsp) begin
            if (!smart || presence == FLAG_TRUE) fan_drive(1'b1, fan_dflt);
            else fan_drive(1'b0, 8'd0);
         end else if (t <= tsp - int'(temp_hyst)) begin
            fan_drive(1'b0, 8'd0);
         end
         if (s <= ssp) pump = (!smart || raining == FLAG_FALSE);
         else if (s >= ssp + int'(soil_hyst)) pump = 1'b0;
      endfunction

      function void take_command(req_type r);
         logic       on, manual;
         logic [7:0] v;
         rsp_type    e;
         on     = (r.argument == ARG_ON);
         manual = (mode == MD_MANUAL);
         case (r.opcode)
            OP_TICK: climate_tick($signed(r.temperature), int'(r.soil_percent));
            OP_MODE: begin
               if (r.argument <= 16'(MD_SMART)) mode = r.argument[1:0];
               fan_blk  = 1'b0;
               pump_blk = 1'b0;
            end
            OP_PRESENCE: presence = r.argument[7:0];
            OP_RAIN:     raining  = r.argument[7:0];
            OP_LAMP: begin
               lamp  = on;
               armed = on;
            end
            OP_PUMP: begin
               if (!manual) pump_blk = 1'b1;
               else pump = on;
            end
            OP_FAN: begin
               if (!manual) begin
                  fan_blk = 1'b1;
               end else if (on) begin
                  if (last_duty == 8'd0) last_duty = fan_dflt;
                  fan_drive(1'b1, last_duty);
               end else begin
                  fan_drive(1'b0, 8'd0);
               end
            end
            OP_FAN_SPEED: begin
               if (manual) begin
                  v = (r.argument > 16'(SPEED_MAX)) ? SPEED_MAX : r.argument[7:0];
                  fan_drive(v != 8'd0, v);
                  last_duty = v;
               end
            end
            OP_ZERO_X: begin
               phase = 8'd0;
               gate  = 1'b0;
            end
            OP_DIM_TICK: begin
               if (phase != '1) phase = phase + 8'd1;
               if (lamp && armed && phase == fire_at) gate = 1'b1;
            end
            default: ;
         endcase
         e.mode         = mode;
         e.lamp_on      = lamp;
         e.triac_gate   = gate;
         e.pump_on      = pump;
         e.fan_on       = fan;
         e.fan_duty     = duty;
         e.fan_blocked  = fan_blk;
         e.pump_blocked = pump_blk;
         due_status.push_back(e);
      endfunction

      function string show(rsp_type s);
         return $sformatf("mode=%0d lamp=%0b gate=%0b pump=%0b fan=%0b duty=%0d fblk=%0b pblk=%0b",
                          s.mode, s.lamp_on, s.triac_gate, s.pump_on, s.fan_on,
                          s.fan_duty, s.fan_blocked, s.pump_blocked);
      endfunction

      function void complain(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void match_status(rsp_type got);
         rsp_type e;
         if (due_status.size() == 0) begin
            complain({"status with nothing owed: ", show(got)});
            return;
         end
         e = due_status.pop_front();
         if (got.mode !== e.mode || got.lamp_on !== e.lamp_on ||
             got.triac_gate !== e.triac_gate || got.pump_on !== e.pump_on ||
             got.fan_on !== e.fan_on || got.fan_duty !== e.fan_duty ||
             got.fan_blocked !== e.fan_blocked || got.pump_blocked !== e.pump_blocked)
            complain({"status mismatch: want ", show(e), " got ", show(got)});
      endfunction

      function int pending();
         return due_status.size();
      endfunction

      function void close();
         if (due_status.size() != 0)
            complain($sformatf("%0d statuses never arrived", due_status.size()));
      endfunction
   endclass

   logic clock;
   logic reset;

   cidc_chan_if #(.payload_type(req_type)) req_if ();
   cidc_chan_if #(.payload_type(rsp_type)) rsp_if ();
   cidc_chan_if #(.payload_type(csr_type)) csr_if ();

   climate_irrigation_dimmer_controller DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   controller_shadow shadow;
   int sent;          // decoded commands handed over so far
   int hold_left;     // cycles the status side still has to hold ready low
   int tx_calm_left;  // transfers the command side still sends back to back

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the handshake locks up
   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

   // Idle length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Switch-style argument: mostly exactly on or off, sometimes any 16-bit value
   function automatic logic [15:0] pick_switch_arg();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return ARG_ON;
      if (r < 85) return 16'd0;
      return 16'($urandom);
   endfunction

   // Fields a command does not use still carry random bits
   function automatic req_type command(logic [3:0] op, logic [15:0] arg);
      req_type r;
      r.opcode       = op;
      r.argument     = arg;
      r.temperature  = 12'($urandom);
      r.soil_percent = 7'($urandom);
      return r;
   endfunction

   function automatic req_type climate_probe(logic [11:0] t, logic [6:0] s);
      req_type r;
      r              = command(OP_TICK, 16'($urandom));
      r.temperature  = t;
      r.soil_percent = s;
      return r;
   endfunction

   // One command transfer. The shadow learns it at the accepting edge. With no
   // idle after it, valid stays high and the next call swaps the payload in the
   // same step, so valid is never dropped and raised within one step.
   task automatic offer(req_type r);
      int gap;
      req_if.data  <= r;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      shadow.take_command(r);
      if (r.opcode <= OP_DIM_TICK) sent++;
      if (hold_left > 0) begin
         gap = 0;  // keep pushing so the block backs up into the input
      end else if (tx_calm_left > 0) begin
         gap = 0;
         tx_calm_left--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 39) == 0) tx_calm_left = $urandom_range(15, 50);
      end
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and let every owed status come back before touching registers
   task automatic settle();
      req_if.valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [11:0] val);
      csr_type w;
      w.index = idx;
      w.data  = val;
      csr_if.data  <= w;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      shadow.write_reg(idx, val);
   endtask

   // Full register set plus one write to an undecoded index
   task automatic load_regs(logic [11:0] tsp, logic [11:0] tband, logic [11:0] ssp,
                            logic [11:0] sband, logic [11:0] fdef, logic [11:0] fire);
      settle();
      csr_write(REG_TEMP_SETPOINT, tsp);
      csr_write(REG_TEMP_BAND, tband);
      csr_write(REG_SOIL_SETPOINT, ssp);
      csr_write(REG_SOIL_BAND, sband);
      csr_write(REG_FAN_DEFAULT, fdef);
      csr_write(REG_FIRE_ANGLE, fire);
      csr_write(REG_SPARE + 3'($urandom_range(0, 1)), 12'($urandom));
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random traffic in short scenes: climate regulation, manual switching,
   // dimmer half-cycles, and plain noise. One long status-side stall per phase.
   task automatic random_phase(int count);
      int         last_item, r, n, ticks, t, s, tsp;
      logic [3:0] op;
      logic [15:0] arg;
      last_item = sent + count;
      hold_left = $urandom_range(40, 80);
      while (sent < last_item) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            // climate: maybe a mode, presence/rain, then ticks (some pump/fan) near thresholds
            if ($urandom_range(0, 4) != 0) begin
               n = $urandom_range(0, 9);
               if (n < 4)      arg = 16'(MD_AUTO);
               else if (n < 8) arg = 16'(MD_SMART);
               else if (n < 9) arg = 16'(MD_MANUAL);
               else            arg = 16'($urandom);
               offer(command(OP_MODE, arg));
            end
            if ($urandom_range(0, 2) == 0) offer(command(OP_PRESENCE, pick_switch_arg()));
            if ($urandom_range(0, 2) == 0) offer(command(OP_RAIN, pick_switch_arg()));
            repeat ($urandom_range(3, 12)) begin
               if ($urandom_range(0, 9) == 0) begin
                  op = OP_PUMP + 4'($urandom_range(0, 2));
                  offer(command(op, pick_switch_arg()));
               end else begin
                  tsp = shadow.temp_sp;
                  t = tsp - int'(shadow.temp_hyst) - 6
                      + int'($urandom_range(0, int'(shadow.temp_hyst) + 12));
                  if (t < -2048) t = -2048;
                  if (t > 2047) t = 2047;
                  if ($urandom_range(0, 7) == 0) t = $urandom;
                  s = int'(shadow.soil_sp) - 4
                      + int'($urandom_range(0, int'(shadow.soil_hyst) + 8));
                  if (s < 0) s = 0;
                  if (s > 127) s = 127;
                  if ($urandom_range(0, 7) == 0) s = $urandom;
                  offer(climate_probe(12'(t), 7'(s)));
               end
            end
         end else if (r < 55) begin
            // manual switching; sometimes left in an automatic mode to hit the refusals
            if ($urandom_range(0, 3) != 0) offer(command(OP_MODE, 16'(MD_MANUAL)));
            repeat ($urandom_range(2, 8)) begin
               case ($urandom_range(0, 3))
                  0: op = OP_PUMP;
                  1: op = OP_FAN;
                  2: op = OP_FAN_SPEED;
                  default: op = OP_LAMP;
               endcase
               arg = pick_switch_arg();
               if (op == OP_FAN_SPEED && $urandom_range(0, 2) != 0)
                  arg = 16'($urandom_range(0, 300));
               offer(command(op, arg));
            end
         end else if (r < 85) begin
            // dimmer half-cycle: zero cross, lamp, then ticks, sometimes up to or past the angle
            if ($urandom_range(0, 3) != 0) offer(command(OP_ZERO_X, 16'($urandom)));
            if ($urandom_range(0, 1) == 1) offer(command(OP_LAMP, pick_switch_arg()));
            if ($urandom_range(0, 1) == 1) ticks = int'(shadow.fire_at) + $urandom_range(0, 3);
            else ticks = $urandom_range(1, 8);
            repeat (ticks) begin
               if ($urandom_range(0, 29) == 0) offer(command(OP_LAMP, pick_switch_arg()));
               offer(command(OP_DIM_TICK, 16'($urandom)));
            end
         end else begin
            // noise: any opcode, any argument, undecoded ones included
            repeat ($urandom_range(1, 4)) offer(command(4'($urandom), 16'($urandom)));
         end
      end
   endtask

   // Status side: random stalls, calm stretches, and the long hold asked for
   // by the command side. Checks happen only at edges where ready was high.
   initial begin
      int gap, calm;
      calm = 0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            while (hold_left > 0) begin
               @(posedge clock);
               hold_left--;
            end
         end else begin
            if (calm > 0) begin
               gap = 0;
               calm--;
            end else begin
               gap = pick_gap();
               if ($urandom_range(0, 39) == 0) calm = $urandom_range(15, 50);
            end
            if (gap > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         if (rsp_if.valid) shadow.match_status(rsp_if.data);
      end
   end

   initial begin
      shadow = new();
      shadow.clear();
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      rsp_if.ready <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass on reset registers (setpoint 300, band 20, soil 40/10)
      offer(command(OP_SPARE_HI, 16'hFFFF));           // undecoded: state echoed
      offer(climate_probe(12'(1250), 7'd0));           // tick in manual: ignored
      offer(command(OP_LAMP, ARG_ON));
      offer(command(OP_ZERO_X, 16'h0000));
      offer(command(OP_FAN_SPEED, 16'd0));             // speed 0 turns fan off
      offer(command(OP_FAN, ARG_ON));                  // last speed 0 -> default duty
      offer(command(OP_FAN_SPEED, 16'hFFFF));          // saturates at 255
      offer(command(OP_FAN, 16'hFFFF));                // not exactly one -> off
      offer(command(OP_PUMP, ARG_ON));
      offer(command(OP_LAMP, 16'd0));
      offer(command(OP_MODE, 16'd3));                  // bad mode kept, flags cleared
      offer(command(OP_MODE, 16'(MD_AUTO)));
      offer(command(OP_PUMP, ARG_ON));                 // refused, pump flag
      offer(command(OP_FAN, ARG_ON));                  // refused, fan flag
      offer(command(OP_FAN_SPEED, 16'd100));           // ignored, no flag
      offer(climate_probe(12'd300, 7'd40));            // at both setpoints: on
      offer(climate_probe(12'd281, 7'd49));            // inside both bands: hold
      offer(climate_probe(12'd280, 7'd50));            // band edges: off
      offer(command(OP_MODE, 16'(MD_SMART)));
      offer(command(OP_PRESENCE, 16'h0000));
      offer(command(OP_RAIN, ARG_ON));
      offer(climate_probe(12'h7FF, 7'd0));             // nobody home, raining: both off
      offer(command(OP_PRESENCE, 16'h0101));           // low byte is one
      offer(climate_probe(12'h7FF, 7'd0));             // fan on, pump still held by rain
      offer(climate_probe(12'h800, 7'd127));           // most negative temp, wettest soil
      offer(command(OP_MODE, 16'(MD_MANUAL)));
      random_phase(100);

      // Low extremes, then high extremes, then in-range random settings, then fully random ones, then the reset values
      load_regs(12'(-400), 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
      random_phase(130);
      load_regs(12'd1250, 12'd500, 12'd100, 12'd100, 12'd255, 12'd255);
      random_phase(130);
      load_regs(12'(int'($urandom_range(0, 1650)) - 400), 12'($urandom_range(0, 500)),
                12'($urandom_range(0, 100)), 12'($urandom_range(0, 100)),
                12'($urandom_range(0, 255)), 12'($urandom_range(3, 20)));
      random_phase(130);
      load_regs(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                12'($urandom), 12'($urandom));
      random_phase(130);
      load_regs(12'(TEMP_SETPOINT_RST), 12'(TEMP_BAND_RST), 12'(SOIL_SETPOINT_RST),
                12'(SOIL_BAND_RST), 12'(FAN_DEFAULT_RST), 12'(FIRE_ANGLE_RST));
      random_phase(110);

      settle();
      repeat (8) @(posedge clock);
      shadow.close();
      if (shadow.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
